@@ hdl/graph_bfs_dfs_traversal_macros.svh @@
// Assertion macros used by the checker file gbt_checker.sv.
`ifndef GRAPH_BFS_DFS_TRAVERSAL_MACROS_SVH
`define GRAPH_BFS_DFS_TRAVERSAL_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define GBT_ASSERT_IMP(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("check failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define GBT_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("check failed");
`endif

@@ hdl/gbt_pkg.sv @@
`timescale 1ns / 1ps
package gbt_pkg;
   localparam int MaxNodes  = 32;
   localparam int MaxDegree = 32;
   localparam int NodeW     = $clog2(MaxNodes);
   localparam int SlotW     = $clog2(MaxDegree);
   localparam int DegW      = $clog2(MaxDegree + 1);
   localparam int CntW      = 6;
   localparam int TimeW     = 7;
   localparam int AddrW     = NodeW + SlotW;

   localparam logic [2:0] ReqAdd   = 3'd0;
   localparam logic [2:0] ReqQuery = 3'd1;
   localparam logic [2:0] ReqBfs   = 3'd2;
   localparam logic [2:0] ReqDfs   = 3'd3;
   localparam logic [2:0] ReqClear = 3'd4;

   localparam logic [1:0] StatOk    = 2'd0;
   localparam logic [1:0] StatFull  = 2'd1;
   localparam logic [1:0] StatRange = 2'd2;

   typedef struct packed {
      logic [2:0] req_type;
      logic [4:0] node_a;
      logic [4:0] node_b;
   } req_type;

   typedef struct packed {
      logic [4:0] node_index;
      logic [4:0] distance;
      logic       reached;
      logic [6:0] discover_time;
      logic [6:0] finish_time;
      logic [4:0] parent_node;
      logic       has_parent;
      logic       is_neighbor;
      logic [1:0] status;
      logic       last;
   } rsp_type;
endpackage

@@ hdl/graph_bfs_dfs_traversal.sv @@
`timescale 1ns / 1ps
// Directed graph store with BFS and DFS. Each request runs to completion and
// req_stall is high until its last result beat has left. Add edge, query and
// clear return one beat. An add or a clear passes through S_ONE, which raises
// the beat, and S_OUT, which holds it until taken. A query alternates S_QRD
// and S_QCHK, one edge read per stored neighbor scanned. BFS and DFS first
// clear per-node state in S_INIT, one node at a time. They then run one
// edge-memory read at a time through S_POP, S_RD and S_EDGE. Last, S_EMIT
// sends one result beat per node. The edge memory has a single read port,
// so it serves one read at a time.
module graph_bfs_dfs_traversal
   import gbt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data,
   input  logic       csr_we,
   input  logic [5:0] csr_data
);
   typedef enum logic [9:0] {
      S_IDLE  = 10'b0000000001,
      S_INIT  = 10'b0000000010,
      S_QRD   = 10'b0000000100,
      S_QCHK  = 10'b0000001000,
      S_POP   = 10'b0000010000,
      S_RD    = 10'b0000100000,
      S_EDGE  = 10'b0001000000,
      S_EMIT  = 10'b0010000000,
      S_OUT   = 10'b0100000000,
      S_ONE   = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;
   logic [CntW-1:0] cnt_reg_ff;
   req_type req_ff, req_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic [DegW-1:0] deg_ff [MaxNodes];
   logic [MaxNodes-1:0] vis_ff;
   logic [4:0] dist_ff [MaxNodes];
   logic [TimeW-1:0] disc_ff [MaxNodes];
   logic [TimeW-1:0] fin_ff [MaxNodes];
   logic [NodeW:0] par_ff [MaxNodes];
   logic [NodeW-1:0] wl_ff [MaxNodes];
   logic [DegW-1:0] cur_ff [MaxNodes];
   logic [CntW-1:0] head_ff, tail_ff, sp_ff, idx_ff, root_ff;
   logic [TimeW-1:0] clk_ff;
   logic [NodeW-1:0] u_ff;
   logic [DegW-1:0] k_ff;
   rsp_type rsp_ff;
   logic rsp_valid_ff;

   logic [CntW-1:0] cnt_act;
   logic ram_we;
   logic [AddrW-1:0] ram_waddr, ram_raddr;
   logic [NodeW-1:0] ram_rdata;
   logic is_dfs;
   logic [NodeW-1:0] a_idx, v, top;
   logic v_ok;
   rsp_type idle_rsp, emit_rsp;

   always_comb begin
      if (cnt_reg_ff == '0) cnt_act = CntW'(1);
      else if (cnt_reg_ff > CntW'(MaxNodes)) cnt_act = CntW'(MaxNodes);
      else cnt_act = cnt_reg_ff;
   end

   assign a_idx = req_ff.node_a;
   assign is_dfs = (req_ff.req_type == ReqDfs);
   assign v = ram_rdata;
   assign v_ok = ({1'b0, v} < cnt_ff) && !vis_ff[v];
   assign top = wl_ff[sp_ff[NodeW-1:0] - NodeW'(1)];
   assign req_in = req_data;
   assign cnt_in = cnt_act;

   assign ram_we = (state_ff == S_IDLE) && req_valid && !rsp_valid_ff
      && req_data.req_type == ReqAdd && {1'b0, req_data.node_a} < cnt_act
      && {1'b0, req_data.node_b} < cnt_act && deg_ff[req_data.node_a] < DegW'(MaxDegree);
   assign ram_waddr = {req_data.node_a, deg_ff[req_data.node_a][SlotW-1:0]};
   assign ram_raddr = {u_ff, k_ff[SlotW-1:0]};

   gbt_edge_ram u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (req_data.node_b),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign req_stall = (state_ff != S_IDLE) || rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_reg_ff <= CntW'(MaxNodes);
      end else if (csr_we) begin
         cnt_reg_ff <= csr_data;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (req_valid && !req_stall) begin
            unique case (req_data.req_type) inside
               ReqAdd, ReqClear: state_in = S_ONE;
               ReqQuery: state_in = S_QRD;
               ReqBfs: state_in = ({1'b0, req_data.node_a} < cnt_act) ? S_INIT : S_ONE;
               ReqDfs: state_in = S_INIT;
               default: state_in = S_IDLE;
            endcase
         end
         default: state_in = state_ff;
      endcase
   end

   always_comb begin
      idle_rsp = '0;
      idle_rsp.last = 1'b1;
      if (req_data.req_type == ReqAdd) begin
         if (!({1'b0, req_data.node_a} < cnt_act && {1'b0, req_data.node_b} < cnt_act))
            idle_rsp.status = StatRange;
         else if (!(deg_ff[req_data.node_a] < DegW'(MaxDegree)))
            idle_rsp.status = StatFull;
      end else if (req_data.req_type == ReqBfs && !({1'b0, req_data.node_a} < cnt_act)) begin
         idle_rsp.status = StatRange;
      end
      emit_rsp = '0;
      emit_rsp.node_index = idx_ff[NodeW-1:0];
      emit_rsp.last = (idx_ff == cnt_ff - CntW'(1));
      if (is_dfs) begin
         emit_rsp.discover_time = disc_ff[idx_ff[NodeW-1:0]];
         emit_rsp.finish_time = fin_ff[idx_ff[NodeW-1:0]];
         emit_rsp.has_parent = !par_ff[idx_ff[NodeW-1:0]][NodeW];
         emit_rsp.parent_node = par_ff[idx_ff[NodeW-1:0]][NodeW]
            ? '0 : par_ff[idx_ff[NodeW-1:0]][NodeW-1:0];
      end else begin
         emit_rsp.distance = dist_ff[idx_ff[NodeW-1:0]];
         emit_rsp.reached = vis_ff[idx_ff[NodeW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MaxNodes; i++) deg_ff[i] <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid && !req_stall) begin
                  req_ff <= req_in;
                  cnt_ff <= cnt_in;
                  idx_ff <= '0;
                  k_ff <= '0;
                  u_ff <= req_data.node_a;
                  rsp_ff <= idle_rsp;
                  if (req_data.req_type == ReqAdd) begin
                     if (ram_we)
                        deg_ff[req_data.node_a] <= deg_ff[req_data.node_a] + DegW'(1);
                  end else if (req_data.req_type == ReqClear) begin
                     for (int i = 0; i < MaxNodes; i++) deg_ff[i] <= '0;
                  end
               end
               state_ff <= state_in;
            end
            S_ONE: begin
               rsp_valid_ff <= 1'b1;
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_valid_ff) state_ff <= S_IDLE;
               else if (!rsp_stall) rsp_valid_ff <= 1'b0;
            end
            S_QRD: begin
               if (!({1'b0, a_idx} < cnt_ff)) begin
                  rsp_ff.status <= StatRange;
                  state_ff <= S_ONE;
               end else if (k_ff < deg_ff[a_idx] && !rsp_ff.is_neighbor) begin
                  state_ff <= S_QCHK;
               end else begin
                  state_ff <= S_ONE;
               end
            end
            S_QCHK: begin
               if (ram_rdata == req_ff.node_b) rsp_ff.is_neighbor <= 1'b1;
               k_ff <= k_ff + DegW'(1);
               state_ff <= S_QRD;
            end
            S_INIT: begin
               vis_ff[idx_ff[NodeW-1:0]] <= 1'b0;
               dist_ff[idx_ff[NodeW-1:0]] <= '0;
               disc_ff[idx_ff[NodeW-1:0]] <= '0;
               fin_ff[idx_ff[NodeW-1:0]] <= '0;
               par_ff[idx_ff[NodeW-1:0]] <= (NodeW+1)'(MaxNodes);
               cur_ff[idx_ff[NodeW-1:0]] <= '0;
               if (idx_ff == cnt_ff - CntW'(1)) begin
                  head_ff <= '0;
                  sp_ff <= '0;
                  root_ff <= '0;
                  clk_ff <= '0;
                  if (is_dfs) begin
                     state_ff <= S_POP;
                  end else begin
                     wl_ff[0] <= a_idx;
                     tail_ff <= CntW'(1);
                     state_ff <= S_POP;
                  end
               end else begin
                  idx_ff <= idx_ff + CntW'(1);
               end
            end
            S_POP: begin
               if (!is_dfs) begin
                  if (head_ff == CntW'(0) && tail_ff == CntW'(1) && !vis_ff[a_idx])
                     vis_ff[a_idx] <= 1'b1;
                  if (head_ff < tail_ff && head_ff < CntW'(MaxNodes)) begin
                     u_ff <= wl_ff[head_ff[NodeW-1:0]];
                     head_ff <= head_ff + CntW'(1);
                     k_ff <= '0;
                     state_ff <= S_RD;
                  end else begin
                     idx_ff <= '0;
                     state_ff <= S_EMIT;
                  end
               end else if (sp_ff == '0) begin
                  if (root_ff == cnt_ff) begin
                     idx_ff <= '0;
                     state_ff <= S_EMIT;
                  end else begin
                     root_ff <= root_ff + CntW'(1);
                     if (!vis_ff[root_ff[NodeW-1:0]]) begin
                        clk_ff <= clk_ff + TimeW'(1);
                        disc_ff[root_ff[NodeW-1:0]] <= clk_ff + TimeW'(1);
                        vis_ff[root_ff[NodeW-1:0]] <= 1'b1;
                        wl_ff[0] <= root_ff[NodeW-1:0];
                        sp_ff <= CntW'(1);
                     end
                  end
               end else begin
                  u_ff <= top;
                  k_ff <= cur_ff[top];
                  if (cur_ff[top] < deg_ff[top]) begin
                     cur_ff[top] <= cur_ff[top] + DegW'(1);
                     state_ff <= S_RD;
                  end else begin
                     sp_ff <= sp_ff - CntW'(1);
                     clk_ff <= clk_ff + TimeW'(1);
                     fin_ff[top] <= clk_ff + TimeW'(1);
                  end
               end
            end
            S_RD: begin
               if (!is_dfs && !(k_ff < deg_ff[u_ff])) state_ff <= S_POP;
               else state_ff <= S_EDGE;
            end
            S_EDGE: begin
               if (!is_dfs) begin
                  if (v_ok && tail_ff < CntW'(MaxNodes)) begin
                     vis_ff[v] <= 1'b1;
                     dist_ff[v] <= dist_ff[u_ff] + 5'd1;
                     wl_ff[tail_ff[NodeW-1:0]] <= v;
                     tail_ff <= tail_ff + CntW'(1);
                  end
                  k_ff <= k_ff + DegW'(1);
                  state_ff <= S_RD;
               end else begin
                  if (v_ok && sp_ff < CntW'(MaxNodes)) begin
                     par_ff[v] <= {1'b0, u_ff};
                     clk_ff <= clk_ff + TimeW'(1);
                     disc_ff[v] <= clk_ff + TimeW'(1);
                     vis_ff[v] <= 1'b1;
                     wl_ff[sp_ff[NodeW-1:0]] <= v;
                     sp_ff <= sp_ff + CntW'(1);
                  end
                  state_ff <= S_POP;
               end
            end
            S_EMIT: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  if (idx_ff == cnt_ff) begin
                     rsp_valid_ff <= 1'b0;
                     state_ff <= S_IDLE;
                  end else begin
                     rsp_valid_ff <= 1'b1;
                     rsp_ff <= emit_rsp;
                     idx_ff <= idx_ff + CntW'(1);
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

@@ hdl/gbt_edge_ram.sv @@
`timescale 1ns / 1ps
module gbt_edge_ram
   import gbt_pkg::*;
(
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [NodeW-1:0] wr_data,
   input  logic [AddrW-1:0] rd_addr,
   output logic [NodeW-1:0] rd_data
);
   logic [NodeW-1:0] mem [MaxNodes*MaxDegree];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

@@ hdl/gbt_checker.sv @@
`timescale 1ns / 1ps
`include "graph_bfs_dfs_traversal_macros.svh"
module gbt_checker
   import gbt_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);
   `GBT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))
   `GBT_ASSERT_IMP(a_busy_out, clock, reset, rsp_valid, req_stall)
   `GBT_ASSERT_NEXT(a_accept_quiet, clock, reset, req_valid && !req_stall, !rsp_valid)
   `GBT_ASSERT_NEXT(a_last_done, clock, reset, rsp_valid && !rsp_stall && rsp_data.last, !rsp_valid)
   `GBT_ASSERT_IMP(a_status, clock, reset, rsp_valid, rsp_data.status != 2'd3)
endmodule

bind graph_bfs_dfs_traversal gbt_checker u_gbt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
